### hdl/isrd_pkg.sv
// shared types, codes and constants of the indexed sprite row decoder
package isrd_pkg;

    // register reset value and stream layout
    localparam logic [15:0] HEADER_SKIP_RESET = 16'h0600;
    localparam logic [15:0] PALETTE_BYTES     = 16'h0200;
    localparam int          PALETTE_ENTRIES   = 256;
    localparam int          PALETTE_WIDTH     = 12;

    // configuration register indexes
    localparam logic REG_HEADER_SKIP = 1'b0;

    // result kinds
    localparam logic [1:0] KIND_IMAGE = 2'd0;
    localparam logic [1:0] KIND_ROW   = 2'd1;
    localparam logic [1:0] KIND_PIXEL = 2'd2;
    localparam logic [1:0] KIND_BAD   = 2'd3;

    // bad row reasons
    localparam logic ERR_END_BELOW_LEAD = 1'b0;
    localparam logic ERR_END_PAST_WIDTH = 1'b1;

    // parser phase, one-hot
    typedef enum logic [4:0] {
        PH_SKIP   = 5'b00001,
        PH_DIMS   = 5'b00010,
        PH_PAL    = 5'b00100,
        PH_ROWHDR = 5'b01000,
        PH_DATA   = 5'b10000
    } phase_t;

    // result fields waiting for the palette read
    typedef struct packed {
        logic [1:0]  kind;
        logic        error_code;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [15:0] row;
        logic [15:0] column;
        logic        last_in_row;
    } pend_t;

endpackage

### hdl/isrd_ram.sv
// generic one-write one-read RAM with registered read data
module isrd_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered read port, holds while rd_en is low
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/indexed_sprite_row_decoder_top.sv
// top level of the indexed sprite row decoder: stream parser, palette and result register
//
// The block takes one byte of a sprite file per cycle while s_ready is high and gives at most
// one result word per byte. After header_skip bytes it reads each image's width and height,
// loads its 256-entry 12-bit palette, then per row announces a row start and turns each index
// byte into an RGBA pixel (magenta is fully transparent); rows are numbered bottom-up. A
// malformed row yields one bad-row word and the block then ignores all input until reset.
// Each accepted byte loads the registered palette RAM read and the pending stage; the output
// register then loads from them once it is free, and the block can take a new byte while
// earlier results are still in flight. s_ready drops only while a result is held back by
// m_ready. The user must write header_skip over the APB port, at byte address 0, only while
// the block is idle; the block itself does not enforce this.
module indexed_sprite_row_decoder_top (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    // result stream
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic        m_error_code,
    output logic [15:0] m_image_width,
    output logic [15:0] m_image_height,
    output logic [15:0] m_row,
    output logic [15:0] m_column,
    output logic [7:0]  m_red,
    output logic [7:0]  m_green,
    output logic [7:0]  m_blue,
    output logic [7:0]  m_alpha,
    output logic        m_last_in_row,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int PAL_AW = $clog2(isrd_pkg::PALETTE_ENTRIES);

    // parser state
    logic [15:0]          header_skip_reg;
    isrd_pkg::phase_t     phase_reg, phase_next;
    logic [15:0]          byte_count_reg, byte_count_next;
    logic [7:0]           low_byte_reg, low_byte_next;
    logic [15:0]          width_reg, width_next;
    logic [15:0]          height_reg, height_next;
    logic [15:0]          rows_done_reg, rows_done_next;
    logic [15:0]          leading_reg, leading_next;
    logic [15:0]          bytes_left_reg, bytes_left_next;
    logic [15:0]          column_reg, column_next;
    logic                 halted_reg, halted_next;

    // pipeline
    logic                 pend_valid_reg;
    isrd_pkg::pend_t      pend_reg, pend_next;
    logic                 res_valid;
    logic                 out_valid_reg;
    isrd_pkg::pend_t      out_reg;
    logic [7:0]           red_reg, green_reg, blue_reg, alpha_reg;

    logic                 accept;
    logic                 pend_adv;
    logic                 cfg_write;

    // working values
    isrd_pkg::phase_t     eff_phase;
    logic [15:0]          eff_count;
    logic [15:0]          word_val;
    logic [15:0]          rows_inc;
    logic [15:0]          count_inc;
    logic [15:0]          left_dec;

    // palette
    logic                 pal_wr_en;
    logic [PAL_AW-1:0]    pal_wr_addr;
    logic [isrd_pkg::PALETTE_WIDTH-1:0] pal_wr_data;
    logic [isrd_pkg::PALETTE_WIDTH-1:0] pal_rd_data;
    logic [7:0]           red_c, green_c, blue_c, alpha_c;

    // handshakes
    assign pend_adv = !out_valid_reg || m_ready;
    assign s_ready  = !pend_valid_reg || pend_adv;
    assign accept   = s_valid && s_ready;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == isrd_pkg::REG_HEADER_SKIP) ? {16'd0, header_skip_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_skip_reg <= isrd_pkg::HEADER_SKIP_RESET;
        end else if (cfg_write && paddr[2] == isrd_pkg::REG_HEADER_SKIP) begin
            header_skip_reg <= pwdata[15:0];
        end
    end

    assign word_val  = {s_data_byte, low_byte_reg};
    assign rows_inc  = rows_done_reg + 16'd1;
    assign count_inc = eff_count + 16'd1;
    assign left_dec  = bytes_left_reg - 16'd1;

    // stream parser
    always_comb begin
        phase_next      = phase_reg;
        byte_count_next = byte_count_reg;
        low_byte_next   = low_byte_reg;
        width_next      = width_reg;
        height_next     = height_reg;
        rows_done_next  = rows_done_reg;
        leading_next    = leading_reg;
        bytes_left_next = bytes_left_reg;
        column_next     = column_reg;
        halted_next     = halted_reg;
        res_valid       = 1'b0;
        pend_next       = '0;
        eff_phase       = phase_reg;
        eff_count       = byte_count_reg;
        pal_wr_en       = 1'b0;

        // header skip ends on the byte that reaches the count
        if (phase_reg == isrd_pkg::PH_SKIP && byte_count_reg >= header_skip_reg) begin
            eff_phase = isrd_pkg::PH_DIMS;
            eff_count = 16'd0;
        end

        if (accept && !halted_reg) begin
            case (eff_phase)
                isrd_pkg::PH_SKIP: begin
                    byte_count_next = byte_count_reg + 16'd1;
                end
                isrd_pkg::PH_DIMS: begin
                    phase_next = isrd_pkg::PH_DIMS;
                    case (eff_count[1:0])
                        2'd1:    width_next    = word_val;
                        2'd3:    height_next   = word_val;
                        default: low_byte_next = s_data_byte;
                    endcase
                    if (eff_count >= 16'd3) begin
                        phase_next      = isrd_pkg::PH_PAL;
                        byte_count_next = 16'd0;
                        rows_done_next  = 16'd0;
                        res_valid       = 1'b1;
                        pend_next.kind         = isrd_pkg::KIND_IMAGE;
                        pend_next.image_width  = width_reg;
                        pend_next.image_height = word_val;
                    end else begin
                        byte_count_next = count_inc;
                    end
                end
                isrd_pkg::PH_PAL: begin
                    if (!eff_count[0]) begin
                        low_byte_next = s_data_byte;
                    end else begin
                        pal_wr_en = 1'b1;
                    end
                    byte_count_next = count_inc;
                    if (count_inc >= isrd_pkg::PALETTE_BYTES) begin
                        phase_next      = (rows_done_reg >= height_reg) ? isrd_pkg::PH_DIMS
                                                                        : isrd_pkg::PH_ROWHDR;
                        byte_count_next = 16'd0;
                    end
                end
                isrd_pkg::PH_ROWHDR: begin
                    case (eff_count[1:0])
                        2'd1: begin
                            leading_next    = word_val;
                            byte_count_next = count_inc;
                        end
                        2'd3: begin
                            rows_done_next         = rows_inc;
                            res_valid              = 1'b1;
                            pend_next.image_width  = width_reg;
                            pend_next.image_height = height_reg;
                            pend_next.row          = height_reg - rows_inc;
                            pend_next.column       = leading_reg;
                            if (word_val < leading_reg) begin
                                halted_next          = 1'b1;
                                pend_next.kind       = isrd_pkg::KIND_BAD;
                                pend_next.error_code = isrd_pkg::ERR_END_BELOW_LEAD;
                            end else if (word_val > width_reg) begin
                                halted_next          = 1'b1;
                                pend_next.kind       = isrd_pkg::KIND_BAD;
                                pend_next.error_code = isrd_pkg::ERR_END_PAST_WIDTH;
                            end else begin
                                pend_next.kind  = isrd_pkg::KIND_ROW;
                                bytes_left_next = word_val - leading_reg;
                                column_next     = leading_reg;
                                byte_count_next = 16'd0;
                                if (word_val == leading_reg) begin
                                    // empty run ends the row at once
                                    phase_next = (rows_inc >= height_reg) ? isrd_pkg::PH_DIMS
                                                                          : isrd_pkg::PH_ROWHDR;
                                end else begin
                                    phase_next = isrd_pkg::PH_DATA;
                                end
                            end
                        end
                        default: begin
                            low_byte_next   = s_data_byte;
                            byte_count_next = count_inc;
                        end
                    endcase
                end
                isrd_pkg::PH_DATA: begin
                    bytes_left_next        = left_dec;
                    column_next            = column_reg + 16'd1;
                    res_valid              = 1'b1;
                    pend_next.kind         = isrd_pkg::KIND_PIXEL;
                    pend_next.image_width  = width_reg;
                    pend_next.image_height = height_reg;
                    pend_next.row          = height_reg - rows_done_reg;
                    pend_next.column       = column_reg;
                    pend_next.last_in_row  = (left_dec == 16'd0);
                    if (left_dec == 16'd0) begin
                        phase_next      = (rows_done_reg >= height_reg) ? isrd_pkg::PH_DIMS
                                                                        : isrd_pkg::PH_ROWHDR;
                        byte_count_next = 16'd0;
                    end
                end
                default: begin
                    phase_next      = isrd_pkg::PH_SKIP;
                    byte_count_next = 16'd0;
                end
            endcase
        end
    end

    // palette entry: low nibble of the second byte over the whole first byte
    assign pal_wr_addr = eff_count[PAL_AW:1];
    assign pal_wr_data = {s_data_byte[3:0], low_byte_reg};

    isrd_ram #(
        .WIDTH (isrd_pkg::PALETTE_WIDTH),
        .DEPTH (isrd_pkg::PALETTE_ENTRIES)
    ) u_palette (
        .aclk    (aclk),
        .wr_en   (pal_wr_en),
        .wr_addr (pal_wr_addr),
        .wr_data (pal_wr_data),
        .rd_en   (accept),
        .rd_addr (s_data_byte),
        .rd_data (pal_rd_data)
    );

    // colour expansion by nibble replication
    always_comb begin
        red_c   = 8'd0;
        green_c = 8'd0;
        blue_c  = 8'd0;
        alpha_c = 8'd0;
        if (pend_reg.kind == isrd_pkg::KIND_PIXEL) begin
            red_c   = {pal_rd_data[11:8], pal_rd_data[11:8]};
            green_c = {pal_rd_data[7:4], pal_rd_data[7:4]};
            blue_c  = {pal_rd_data[3:0], pal_rd_data[3:0]};
            alpha_c = (red_c == 8'hff && green_c == 8'h00 && blue_c == 8'hff) ? 8'h00 : 8'hff;
        end
    end

    // parser state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= isrd_pkg::PH_SKIP;
            byte_count_reg <= 16'd0;
            low_byte_reg   <= 8'd0;
            width_reg      <= 16'd0;
            height_reg     <= 16'd0;
            rows_done_reg  <= 16'd0;
            leading_reg    <= 16'd0;
            bytes_left_reg <= 16'd0;
            column_reg     <= 16'd0;
            halted_reg     <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            byte_count_reg <= byte_count_next;
            low_byte_reg   <= low_byte_next;
            width_reg      <= width_next;
            height_reg     <= height_next;
            rows_done_reg  <= rows_done_next;
            leading_reg    <= leading_next;
            bytes_left_reg <= bytes_left_next;
            column_reg     <= column_next;
            halted_reg     <= halted_next;
        end
    end

    // pending stage valid and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                pend_valid_reg <= accept && res_valid;
            end
            if (pend_adv) begin
                out_valid_reg <= pend_valid_reg;
            end
        end
    end

    // pending and output word payload
    always_ff @(posedge aclk) begin
        if (s_ready) begin
            pend_reg <= pend_next;
        end
        if (pend_adv) begin
            out_reg   <= pend_reg;
            red_reg   <= red_c;
            green_reg <= green_c;
            blue_reg  <= blue_c;
            alpha_reg <= alpha_c;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_kind         = out_reg.kind;
    assign m_error_code   = out_reg.error_code;
    assign m_image_width  = out_reg.image_width;
    assign m_image_height = out_reg.image_height;
    assign m_row          = out_reg.row;
    assign m_column       = out_reg.column;
    assign m_red          = red_reg;
    assign m_green        = green_reg;
    assign m_blue         = blue_reg;
    assign m_alpha        = alpha_reg;
    assign m_last_in_row  = out_reg.last_in_row;

endmodule

### verif/tb_top.sv
// self-checking testbench for the indexed sprite row decoder: byte stream in, pixel words out
`timescale 1ns / 100ps

module tb_top;

    localparam int          IDLE_GAP         = 4;
    localparam int          QUIET_LIMIT      = 3000;
    localparam logic [2:0]  ADDR_HEADER_SKIP = {isrd_pkg::REG_HEADER_SKIP, 2'b00};
    localparam logic [2:0]  ADDR_UNMAPPED    = 3'h4;
    localparam logic [11:0] MAGENTA_ENTRY    = 12'hf0f;

    // one result word as the block presents it
    typedef struct packed {
        logic [1:0]  kind;
        logic        error_code;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [15:0] row;
        logic [15:0] column;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic        last_in_row;
    } sprite_word_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'h00;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [1:0]  m_kind;
    logic        m_error_code;
    logic [15:0] m_image_width;
    logic [15:0] m_image_height;
    logic [15:0] m_row;
    logic [15:0] m_column;
    logic [7:0]  m_red;
    logic [7:0]  m_green;
    logic [7:0]  m_blue;
    logic [7:0]  m_alpha;
    logic        m_last_in_row;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;

    // decoder mirror: register, parse state and palette
    sprite_word_t      expected_words[$];
    logic [15:0]       skip_setting  = isrd_pkg::HEADER_SKIP_RESET;
    isrd_pkg::phase_t  parse_phase   = isrd_pkg::PH_SKIP;
    logic [15:0]       byte_index    = '0;
    logic [7:0]        held_byte     = '0;
    logic [15:0]       cur_width     = '0;
    logic [15:0]       cur_height    = '0;
    logic [15:0]       rows_read     = '0;
    logic [15:0]       lead_count    = '0;
    logic [15:0]       pixels_left   = '0;
    logic [15:0]       next_column   = '0;
    logic [11:0]       palette_mirror [isrd_pkg::PALETTE_ENTRIES];
    logic              stream_halted = 1'b0;

    // stimulus control and run statistics
    logic [7:0] hot_colors[$];
    int         ready_levels [4] = '{100, 80, 45, 15};
    int         ready_pct        = 100;
    int         pattern_left     = 0;
    int         hold_left        = 0;
    int         burst_left       = 0;
    bit         sender_gaps_on   = 1'b1;
    int         quiet_cycles     = 0;
    int         fail_count       = 0;
    int         bytes_sent       = 0;
    int         skip_writes      = 0;
    int         images_seen      = 0;
    int         rows_seen        = 0;
    int         pixels_seen      = 0;
    int         bad_seen         = 0;
    logic       bad_reason       = isrd_pkg::ERR_END_PAST_WIDTH;

    indexed_sprite_row_decoder_top i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_error_code   (m_error_code),
        .m_image_width  (m_image_width),
        .m_image_height (m_image_height),
        .m_row          (m_row),
        .m_column       (m_column),
        .m_red          (m_red),
        .m_green        (m_green),
        .m_blue         (m_blue),
        .m_alpha        (m_alpha),
        .m_last_in_row  (m_last_in_row),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // queue one expected word, dimensions taken from the current image
    function automatic void queue_word(input logic [1:0] kind, input logic err,
                                       input logic [15:0] row_no, input logic [15:0] col,
                                       input logic [7:0] red, input logic [7:0] green,
                                       input logic [7:0] blue, input logic [7:0] alpha,
                                       input logic last);
        expected_words.push_back({kind, err, cur_width, cur_height, row_no, col,
                                  red, green, blue, alpha, last});
    endfunction

    // after a row or a palette: next row header, or next image once all rows are in
    function automatic void close_row();
        parse_phase = (rows_read >= cur_height) ? isrd_pkg::PH_DIMS : isrd_pkg::PH_ROWHDR;
        byte_index  = '0;
    endfunction

    // advance the mirror by one accepted byte
    function automatic void decode_byte(input logic [7:0] d);
        logic [15:0] line_end;
        logic [15:0] row_no;
        logic [11:0] entry;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        if (stream_halted)
            return;
        // header skip, cut short when the setting is at or below the count
        if (parse_phase == isrd_pkg::PH_SKIP) begin
            if (byte_index < skip_setting) begin
                byte_index++;
                return;
            end
            parse_phase = isrd_pkg::PH_DIMS;
            byte_index  = '0;
        end
        case (parse_phase)
            isrd_pkg::PH_DIMS: begin
                case (byte_index[1:0])
                    2'd1:    cur_width  = {d, held_byte};
                    2'd3:    cur_height = {d, held_byte};
                    default: held_byte  = d;
                endcase
                if (byte_index >= 16'd3) begin
                    parse_phase = isrd_pkg::PH_PAL;
                    byte_index  = '0;
                    rows_read   = '0;
                    queue_word(isrd_pkg::KIND_IMAGE, 1'b0, '0, '0,
                               8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
                end else begin
                    byte_index++;
                end
            end
            isrd_pkg::PH_PAL: begin
                if (!byte_index[0])
                    held_byte = d;
                else
                    palette_mirror[byte_index[8:1]] = {d[3:0], held_byte};
                byte_index++;
                if (byte_index >= isrd_pkg::PALETTE_BYTES)
                    close_row();
            end
            isrd_pkg::PH_ROWHDR: begin
                if (byte_index[1:0] != 2'd3) begin
                    if (byte_index[1:0] == 2'd1)
                        lead_count = {d, held_byte};
                    else
                        held_byte = d;
                    byte_index++;
                end else begin
                    line_end = {d, held_byte};
                    rows_read++;
                    row_no = cur_height - rows_read;
                    if (line_end < lead_count) begin
                        stream_halted = 1'b1;
                        queue_word(isrd_pkg::KIND_BAD, isrd_pkg::ERR_END_BELOW_LEAD, row_no,
                                   lead_count, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
                    end else if (line_end > cur_width) begin
                        stream_halted = 1'b1;
                        queue_word(isrd_pkg::KIND_BAD, isrd_pkg::ERR_END_PAST_WIDTH, row_no,
                                   lead_count, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
                    end else begin
                        pixels_left = line_end - lead_count;
                        next_column = lead_count;
                        if (pixels_left == 0)
                            close_row();
                        else
                            parse_phase = isrd_pkg::PH_DATA;
                        queue_word(isrd_pkg::KIND_ROW, 1'b0, row_no, lead_count,
                                   8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
                    end
                end
            end
            isrd_pkg::PH_DATA: begin
                // nibble replication, magenta keys out
                entry = palette_mirror[d];
                red   = {2{entry[11:8]}};
                green = {2{entry[7:4]}};
                blue  = {2{entry[3:0]}};
                pixels_left--;
                queue_word(isrd_pkg::KIND_PIXEL, 1'b0, cur_height - rows_read, next_column,
                           red, green, blue,
                           (red == 8'hff && green == 8'h00 && blue == 8'hff) ? 8'h00 : 8'hff,
                           pixels_left == 0);
                next_column++;
                if (pixels_left == 0)
                    close_row();
            end
            default: begin
                parse_phase = isrd_pkg::PH_SKIP;
                byte_index  = '0;
            end
        endcase
    endfunction

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    // send one byte, opening a new burst with a random gap when due
    task automatic send_byte(input logic [7:0] value);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(40, 1);
            gap = sender_gaps_on ? $urandom_range(6, 0) : 0;
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid     <= 1'b1;
        s_data_byte <= value;
        do @(posedge aclk); while (s_ready !== 1'b1);
        decode_byte(value);
        bytes_sent++;
    endtask

    task automatic send_half(input logic [15:0] value);
        send_byte(value[7:0]);
        send_byte(value[15:8]);
    endtask

    // stop sending, let every expected word drain, then give the pipeline time to settle
    task automatic wait_idle();
        s_valid <= 1'b0;
        burst_left = 0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (IDLE_GAP) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        if (addr == ADDR_HEADER_SKIP) begin
            skip_setting = value[15:0];
            skip_writes++;
        end
    endtask

    task automatic check_header_skip();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_HEADER_SKIP;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        compare_field("header_skip", skip_setting, prdata[15:0]);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // 256 palette entries: black at 0, white at 255, magenta keys and near misses
    task automatic send_palette();
        int          hot;
        logic [11:0] entry;
        logic [7:0]  top;
        hot_colors.delete();
        hot = $urandom_range(254, 1);
        for (int i = 0; i < isrd_pkg::PALETTE_ENTRIES; i++) begin
            entry = 12'($urandom());
            top   = 8'($urandom());
            if (i == 0) begin
                entry = 12'h000;
            end else if (i == isrd_pkg::PALETTE_ENTRIES - 1) begin
                entry = 12'hfff;
            end else if (i == hot || $urandom_range(7, 0) == 0) begin
                entry = MAGENTA_ENTRY;
                hot_colors.push_back(8'(i));
            end else if ($urandom_range(15, 0) == 0) begin
                entry = MAGENTA_ENTRY ^ (12'h001 << $urandom_range(11, 0));
                hot_colors.push_back(8'(i));
            end
            send_byte(entry[7:0]);
            send_byte({top[7:4], entry[11:8]});
        end
    endtask

    task automatic start_image(input logic [15:0] w, input logic [15:0] h);
        send_half(w);
        send_half(h);
        send_palette();
    endtask

    function automatic logic [7:0] pick_index();
        if (hot_colors.size() != 0 && $urandom_range(3, 0) == 0)
            return hot_colors[$urandom_range(hot_colors.size() - 1, 0)];
        return 8'($urandom_range(255, 0));
    endfunction

    // well-formed row: header then one index per pixel
    task automatic send_row(input logic [15:0] lead, input logic [15:0] line_end);
        send_half(lead);
        send_half(line_end);
        repeat (line_end - lead) send_byte(pick_index());
    endtask

    // header skip register: reset value, extremes, unmapped address, early end of header
    task automatic test_header_skip();
        logic [31:0] noise;
        noise = $urandom();
        check_header_skip();
        apb_write(ADDR_HEADER_SKIP, {noise[31:16], 16'hffff});
        check_header_skip();
        repeat (20) send_byte(8'($urandom_range(255, 0)));
        wait_idle();
        apb_write(ADDR_UNMAPPED, $urandom());
        check_header_skip();
        // below the bytes already skipped: the next byte opens the first image
        apb_write(ADDR_HEADER_SKIP, {noise[15:0], 16'h0000});
        check_header_skip();
    endtask

    // widest image, run ending exactly at the width, then an empty run
    task automatic test_wide_image();
        start_image(16'hffff, 16'd2);
        send_half(16'hfffc);
        send_half(16'hffff);
        send_byte(8'h00);
        send_byte(hot_colors[0]);
        send_byte(8'hff);
        send_row(16'd7, 16'd7);
    endtask

    task automatic test_zero_height();
        start_image(16'($urandom_range(65535, 0)), 16'd0);
    endtask

    task automatic test_zero_width();
        start_image(16'd0, 16'd1);
        send_row(16'd0, 16'd0);
    endtask

    // a few random images, mostly narrow, now and then very wide or without rows
    task automatic test_random_images();
        int          row_bytes;
        logic [15:0] w;
        logic [15:0] h;
        logic [15:0] lead;
        logic [15:0] run;
        row_bytes = 0;
        while (row_bytes < 60) begin
            // the header is long past, so retuning the register must not disturb the stream
            if ($urandom_range(2, 0) == 0) begin
                wait_idle();
                apb_write(ADDR_HEADER_SKIP, $urandom());
                check_header_skip();
            end
            sender_gaps_on = ($urandom_range(3, 0) != 0);
            w = ($urandom_range(7, 0) == 0) ? 16'($urandom_range(65535, 49))
                                            : 16'($urandom_range(48, 1));
            h = ($urandom_range(9, 0) == 0) ? 16'd0 : 16'($urandom_range(6, 1));
            start_image(w, h);
            repeat (h) begin
                lead = 16'($urandom_range(w, 0));
                run  = 16'($urandom_range((w - lead > 16'd24) ? 16'd24 : w - lead, 0));
                send_row(lead, lead + run);
                row_bytes += 4 + run;
            end
        end
        sender_gaps_on = 1'b1;
    endtask

    // receiver holds off for a long stretch while full rows keep coming
    task automatic test_backpressure();
        sender_gaps_on = 1'b0;
        start_image(16'd64, 16'd3);
        hold_left = 300;
        repeat (3) send_row(16'($urandom_range(40, 0)), 16'd64);
        sender_gaps_on = 1'b1;
    endtask

    // tall image, one good row, then a malformed row; the block ignores the rest
    task automatic test_bad_row();
        logic [15:0] w;
        logic [15:0] lead;
        logic [15:0] line_end;
        w = 16'($urandom_range(40, 1));
        start_image(w, 16'hffff);
        send_row(16'd0, w);
        bad_reason = 1'($urandom_range(1, 0));
        if (bad_reason == isrd_pkg::ERR_END_BELOW_LEAD) begin
            lead     = 16'($urandom_range(65535, 1));
            line_end = 16'($urandom_range(lead - 16'd1, 0));
        end else begin
            line_end = 16'($urandom_range(65535, w + 16'd1));
            lead     = 16'($urandom_range(line_end, 0));
        end
        send_half(lead);
        send_half(line_end);
        repeat (24) send_byte(8'($urandom_range(255, 0)));
    endtask

    // receiver: ready pattern of its own, overridden by a requested hold-off
    always @(posedge aclk) begin
        if (pattern_left == 0) begin
            pattern_left = $urandom_range(200, 20);
            ready_pct    = ready_levels[$urandom_range(3, 0)];
        end
        pattern_left--;
        if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else begin
            m_ready <= ($urandom_range(99, 0) < ready_pct);
        end
    end

    // result checker: every word against the oldest expectation
    always @(posedge aclk) begin
        sprite_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                $error("result word of kind %0d with nothing expected", m_kind);
                fail_count++;
            end else begin
                want = expected_words.pop_front();
                compare_field("kind", 16'(want.kind), 16'(m_kind));
                compare_field("error_code", 16'(want.error_code), 16'(m_error_code));
                compare_field("image_width", want.image_width, m_image_width);
                compare_field("image_height", want.image_height, m_image_height);
                compare_field("row", want.row, m_row);
                compare_field("column", want.column, m_column);
                compare_field("red", 16'(want.red), 16'(m_red));
                compare_field("green", 16'(want.green), 16'(m_green));
                compare_field("blue", 16'(want.blue), 16'(m_blue));
                compare_field("alpha", 16'(want.alpha), 16'(m_alpha));
                compare_field("last_in_row", 16'(want.last_in_row), 16'(m_last_in_row));
                case (want.kind)
                    isrd_pkg::KIND_IMAGE: images_seen++;
                    isrd_pkg::KIND_ROW:   rows_seen++;
                    isrd_pkg::KIND_PIXEL: pixels_seen++;
                    default:              bad_seen++;
                endcase
            end
        end
    end

    // watchdog: too long without a word moving on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[indexed_sprite_row_decoder_top] ERROR");
            $finish;
        end
    end

    // test sequence
    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_header_skip();
        test_wide_image();
        test_zero_height();
        test_zero_width();
        test_random_images();
        test_backpressure();
        test_bad_row();
        wait_idle();
        $display("covered %0d bytes: %0d images, %0d rows, %0d pixels, %0d bad row",
                 bytes_sent, images_seen, rows_seen, pixels_seen, bad_seen);
        $display("halted on bad row reason %0d after %0d header skip writes",
                 bad_reason, skip_writes);
        if (fail_count == 0)
            $display("[indexed_sprite_row_decoder_top] OK");
        else
            $display("[indexed_sprite_row_decoder_top] ERROR");
        $finish;
    end

endmodule

### filelist.f
hdl/isrd_pkg.sv
hdl/isrd_ram.sv
hdl/indexed_sprite_row_decoder_top.sv
verif/tb_top.sv
